// ===== hdl/gnla_pkg.sv =====
`timescale 1ns / 1ps

package gnla_pkg;

    localparam int MAX_MARKS_DEF    = 64;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CX_W = 50;
    localparam int CZ_W = 36;
    localparam int DIST_W = 38;

    localparam logic [15:0] NEAR_RANGE = 16'd6144;
    localparam logic signed [15:0] BEARING_LIMIT = 16'sd3276;
    localparam logic [45:0] INV_GAIN_Q30 = 46'd652032874;
    localparam logic signed [CZ_W-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [DIST_W-1:0] NO_WIDTH_SQ = 38'd10485760000;

    localparam logic signed [CZ_W-1:0] ATAN_TAB [0:23] = '{
        36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
        36'sd67021687,  36'sd33543516,  36'sd16775851,  36'sd8388437,
        36'sd4194283,   36'sd2097149,   36'sd1048576,   36'sd524288,
        36'sd262144,    36'sd131072,    36'sd65536,     36'sd32768,
        36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
        36'sd1024,      36'sd512,       36'sd256,       36'sd128
    };

    localparam logic [2:0] REG_FAR_RANGE    = 3'd0;
    localparam logic [2:0] REG_GATE_NORMAL  = 3'd1;
    localparam logic [2:0] REG_GATE_LARGE   = 3'd2;
    localparam logic [2:0] REG_FRAMES       = 3'd3;
    localparam logic [2:0] REG_YELLOW       = 3'd4;
    localparam logic [2:0] REG_BLUE         = 3'd5;
    localparam logic [2:0] REG_LARGE_ORANGE = 3'd6;

    typedef enum logic [2:0] {
        STAT_FILTERED = 3'd0,
        STAT_MATCHED  = 3'd1,
        STAT_NEW      = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_READY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORDIC,
        ST_SCAN,
        ST_FRAME,
        ST_WIDTH,
        ST_SQRT,
        ST_OUT
    } fsm_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } cord_t;

    typedef struct packed {
        logic issue;
        logic pair_mode;
    } scan_in_t;

    typedef struct packed {
        logic valid;
        logic match;
        logic busy;
    } scan_out_t;

    function automatic logic signed [17:0] round_sat(input logic signed [CX_W-1:0] v);
        logic signed [CX_W:0]    s;
        logic signed [CX_W-30:0] q;
        s = (CX_W+1)'(v) + (CX_W+1)'(64'sd536870912);
        q = (CX_W-29)'(s >>> 30);
        if (q > 131071) begin
            return 18'(131071);
        end else if (q < -131072) begin
            return 18'(-131072);
        end else begin
            return 18'(q);
        end
    endfunction

endpackage

// ===== hdl/gnla_cordic_cell.sv =====
`timescale 1ns / 1ps

module gnla_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  gnla_pkg::cord_t   in_data,
    output logic              out_valid,
    output gnla_pkg::cord_t   out_data
);

    logic              valid_reg;
    gnla_pkg::cord_t   data_reg;
    gnla_pkg::cord_t   data_next;
    logic signed [gnla_pkg::CX_W-1:0] dx;
    logic signed [gnla_pkg::CX_W-1:0] dy;

    always_comb begin
        dx = in_data.y >>> STEP;
        dy = in_data.x >>> STEP;
        if (in_data.z >= 0) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - gnla_pkg::ATAN_TAB[STEP];
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + gnla_pkg::ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/gnla_mark_store.sv =====
`timescale 1ns / 1ps

module gnla_mark_store #(
    parameter int MAX_MARKS = gnla_pkg::MAX_MARKS_DEF,
    localparam int IW = $clog2(MAX_MARKS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [IW-1:0]                 wr_idx,
    input  logic [2:0]                    wr_color,
    input  logic signed [17:0]            wr_x,
    input  logic signed [17:0]            wr_y,
    input  gnla_pkg::scan_in_t            ctl,
    input  logic [IW-1:0]                 rd_a_idx,
    input  logic [IW-1:0]                 rd_b_idx,
    input  logic [2:0]                    ref_color,
    input  logic signed [17:0]            ref_x,
    input  logic signed [17:0]            ref_y,
    input  logic [2:0]                    yellow_code,
    input  logic [2:0]                    blue_code,
    output gnla_pkg::scan_out_t           stat,
    output logic [IW-1:0]                 res_idx,
    output logic [gnla_pkg::DIST_W-1:0]   res_dist
);

    logic [2:0]         mark_color [0:MAX_MARKS-1];
    logic signed [17:0] mark_x     [0:MAX_MARKS-1];
    logic signed [17:0] mark_y     [0:MAX_MARKS-1];

    logic               v1_reg, v2_reg, v3_reg;
    logic [IW-1:0]      idx1_reg, idx2_reg, idx3_reg;
    logic [2:0]         col_a_reg, col_b_reg;
    logic signed [17:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [18:0]        ax_reg, ay_reg;
    logic               match2_reg, match3_reg;
    logic [gnla_pkg::DIST_W-1:0] sqx_reg, sqy_reg;

    logic signed [18:0] dx, dy;
    logic               match_c;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mark_color[wr_idx] <= wr_color;
            mark_x[wr_idx]     <= wr_x;
            mark_y[wr_idx]     <= wr_y;
        end
        col_a_reg <= mark_color[rd_a_idx];
        xa_reg    <= mark_x[rd_a_idx];
        ya_reg    <= mark_y[rd_a_idx];
        col_b_reg <= mark_color[rd_b_idx];
        xb_reg    <= mark_x[rd_b_idx];
        yb_reg    <= mark_y[rd_b_idx];
    end

    always_comb begin
        dx = 19'(xa_reg) - 19'(ctl.pair_mode ? xb_reg : ref_x);
        dy = 19'(ya_reg) - 19'(ctl.pair_mode ? yb_reg : ref_y);
        if (ctl.pair_mode) begin
            match_c = (col_a_reg == yellow_code) && (col_b_reg == blue_code);
        end else begin
            match_c = (col_a_reg == ref_color);
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg   <= rd_a_idx;
        idx2_reg   <= idx1_reg;
        idx3_reg   <= idx2_reg;
        ax_reg     <= dx[18] ? 19'(-dx) : 19'(dx);
        ay_reg     <= dy[18] ? 19'(-dy) : 19'(dy);
        match2_reg <= match_c;
        match3_reg <= match2_reg;
        sqx_reg    <= ax_reg * ax_reg;
        sqy_reg    <= ay_reg * ay_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign stat.valid = v3_reg;
    assign stat.match = match3_reg;
    assign stat.busy  = v1_reg | v2_reg | v3_reg;
    assign res_idx    = idx3_reg;
    assign res_dist   = sqx_reg + sqy_reg;

endmodule

// ===== hdl/gated_nearest_landmark_association.sv =====
`timescale 1ns / 1ps

// Cone map builder. One request at a time: a request runs through the CORDIC chain
// and, for a cone that is kept, a scan of every stored landmark through the distance
// pipeline of the landmark memory. The request that completes the map adds a
// yellow-blue pair sweep over mark_count^2 pairs and an iterative square root.
// Positions come out of a chain of CORDIC cells, one micro-rotation each.
// Landmarks live in a memory with no reset; only entries below the count are read.
// Registers sit at byte address 8*i on a 64-bit port.

module gated_nearest_landmark_association #(
    parameter int MAX_MARKS    = gnla_pkg::MAX_MARKS_DEF,
    parameter int CORDIC_STEPS = gnla_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cone_color,
    input  logic [15:0]        s_cone_range,
    input  logic signed [15:0] s_cone_bearing,
    input  logic               s_frame_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [5:0]         m_landmark_slot,
    output logic signed [17:0] m_pos_x,
    output logic signed [17:0] m_pos_y,
    output logic               m_width_valid,
    output logic [16:0]        m_lane_width
);

    localparam int IW = $clog2(MAX_MARKS);
    localparam int DW = gnla_pkg::DIST_W;

    gnla_pkg::fsm_t state_reg, state_next;

    logic [15:0] far_range_reg;
    logic [34:0] gate_normal_reg, gate_large_reg;
    logic [7:0]  frames_needed_reg;
    logic [2:0]  yellow_reg, blue_reg, large_orange_reg;

    logic [2:0]         color_reg;
    logic [15:0]        range_reg;
    logic signed [15:0] bearing_reg;
    logic               last_reg;

    logic [IW:0] mark_count_reg;
    logic [7:0]  frame_count_reg;
    logic        had_reg;
    logic        map_done_reg;

    logic signed [17:0] px_reg, py_reg;
    logic               keep_reg;
    logic [DW-1:0]      best_reg;
    logic               found_reg;
    logic [IW-1:0]      hit_reg;
    logic [IW:0]        idx_a_reg, idx_b_reg;
    logic [33:0]        sq_v_reg;
    logic [34:0]        sq_res_reg;
    logic [33:0]        sq_bit_reg;

    gnla_pkg::status_t  res_status_reg;
    logic [5:0]         res_slot_reg;
    logic               res_wv_reg;
    logic [16:0]        res_width_reg;

    logic               m_valid_reg;
    logic [2:0]         m_status_reg;
    logic [5:0]         m_slot_reg;
    logic signed [17:0] m_x_reg, m_y_reg;
    logic               m_wv_reg;
    logic [16:0]        m_width_reg;

    gnla_pkg::cord_t ch_data  [0:CORDIC_STEPS];
    logic            ch_valid [0:CORDIC_STEPS];

    logic [45:0]                       prod;
    logic signed [gnla_pkg::CX_W-1:0]  x0;
    logic signed [gnla_pkg::CZ_W-1:0]  z0;

    gnla_pkg::scan_in_t  scan_ctl;
    gnla_pkg::scan_out_t scan_stat;
    logic [IW-1:0]       scan_idx;
    logic [DW-1:0]       scan_dist;

    logic        issue;
    logic        keep_c;
    logic        had_c;
    logic [7:0]  fc_inc;
    logic        width_go;
    logic        wr_en;
    logic        out_free;
    logic        better;
    logic [34:0] sq_trial;

    // polar start vector with quadrant fold
    always_comb begin
        prod = 46'(range_reg) * gnla_pkg::INV_GAIN_Q30;
        x0   = signed'(gnla_pkg::CX_W'(prod));
        z0   = gnla_pkg::CZ_W'(bearing_reg) <<< 17;
        if (z0 > gnla_pkg::HALF_PI_Q30) begin
            z0 = z0 - gnla_pkg::PI_Q30;
            x0 = -x0;
        end else if (z0 < -gnla_pkg::HALF_PI_Q30) begin
            z0 = z0 + gnla_pkg::PI_Q30;
            x0 = -x0;
        end
    end

    assign ch_data[0].x = x0;
    assign ch_data[0].y = '0;
    assign ch_data[0].z = z0;
    assign ch_valid[0]  = (state_reg == gnla_pkg::ST_PREP);

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        gnla_cordic_cell #(
            .STEP(g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (ch_valid[g]),
            .in_data  (ch_data[g]),
            .out_valid(ch_valid[g+1]),
            .out_data (ch_data[g+1])
        );
    end

    assign scan_ctl.issue     = issue;
    assign scan_ctl.pair_mode = (state_reg == gnla_pkg::ST_WIDTH);

    gnla_mark_store #(
        .MAX_MARKS(MAX_MARKS)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (wr_en),
        .wr_idx     (mark_count_reg[IW-1:0]),
        .wr_color   (color_reg),
        .wr_x       (px_reg),
        .wr_y       (py_reg),
        .ctl        (scan_ctl),
        .rd_a_idx   (idx_a_reg[IW-1:0]),
        .rd_b_idx   (idx_b_reg[IW-1:0]),
        .ref_color  (color_reg),
        .ref_x      (px_reg),
        .ref_y      (py_reg),
        .yellow_code(yellow_reg),
        .blue_code  (blue_reg),
        .stat       (scan_stat),
        .res_idx    (scan_idx),
        .res_dist   (scan_dist)
    );

    always_comb begin
        keep_c = (range_reg <= gnla_pkg::NEAR_RANGE) ||
                 ((bearing_reg <= gnla_pkg::BEARING_LIMIT) && (range_reg <= far_range_reg));
        had_c    = had_reg | keep_reg;
        fc_inc   = (frame_count_reg == 8'hFF) ? frame_count_reg : frame_count_reg + 8'd1;
        width_go = last_reg && had_c && (fc_inc >= frames_needed_reg);
        wr_en    = (state_reg == gnla_pkg::ST_FRAME) && keep_reg && !found_reg &&
                   (mark_count_reg < (IW+1)'(MAX_MARKS));
        out_free = !m_valid_reg || m_ready;
        better   = scan_stat.valid && scan_stat.match && (scan_dist < best_reg);
        sq_trial = sq_res_reg + 35'(sq_bit_reg);
    end

    always_comb begin
        state_next = state_reg;
        issue      = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            gnla_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = map_done_reg ? gnla_pkg::ST_OUT : gnla_pkg::ST_PREP;
                end
            end
            gnla_pkg::ST_PREP: begin
                state_next = gnla_pkg::ST_CORDIC;
            end
            gnla_pkg::ST_CORDIC: begin
                if (ch_valid[CORDIC_STEPS]) begin
                    state_next = keep_c ? gnla_pkg::ST_SCAN : gnla_pkg::ST_FRAME;
                end
            end
            gnla_pkg::ST_SCAN, gnla_pkg::ST_WIDTH: begin
                issue = (idx_a_reg < mark_count_reg);
                if (!issue && !scan_stat.busy) begin
                    state_next = (state_reg == gnla_pkg::ST_SCAN) ? gnla_pkg::ST_FRAME
                                                                 : gnla_pkg::ST_SQRT;
                end
            end
            gnla_pkg::ST_FRAME: begin
                state_next = width_go ? gnla_pkg::ST_WIDTH : gnla_pkg::ST_OUT;
            end
            gnla_pkg::ST_SQRT: begin
                if (sq_bit_reg == '0) begin
                    state_next = gnla_pkg::ST_OUT;
                end
            end
            gnla_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = gnla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gnla_pkg::ST_IDLE;
            end
        endcase
    end

    // control state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= gnla_pkg::ST_IDLE;
            far_range_reg     <= 16'd10240;
            gate_normal_reg   <= 35'd2359296;
            gate_large_reg    <= 35'd4624220;
            frames_needed_reg <= 8'd40;
            yellow_reg        <= 3'd0;
            blue_reg          <= 3'd1;
            large_orange_reg  <= 3'd3;
            mark_count_reg    <= '0;
            frame_count_reg   <= '0;
            had_reg           <= 1'b0;
            map_done_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite) begin
                unique case (paddr[5:3])
                    gnla_pkg::REG_FAR_RANGE:    far_range_reg     <= pwdata[15:0];
                    gnla_pkg::REG_GATE_NORMAL:  gate_normal_reg   <= pwdata[34:0];
                    gnla_pkg::REG_GATE_LARGE:   gate_large_reg    <= pwdata[34:0];
                    gnla_pkg::REG_FRAMES:       frames_needed_reg <= pwdata[7:0];
                    gnla_pkg::REG_YELLOW:       yellow_reg        <= pwdata[2:0];
                    gnla_pkg::REG_BLUE:         blue_reg          <= pwdata[2:0];
                    gnla_pkg::REG_LARGE_ORANGE: large_orange_reg  <= pwdata[2:0];
                    default: ;
                endcase
            end
            if (state_reg == gnla_pkg::ST_FRAME) begin
                if (wr_en) begin
                    mark_count_reg <= mark_count_reg + 1'b1;
                end
                if (last_reg && had_c) begin
                    frame_count_reg <= fc_inc;
                    had_reg         <= 1'b0;
                    if (width_go) begin
                        map_done_reg <= 1'b1;
                    end
                end else begin
                    had_reg <= had_c;
                end
            end
            if (state_reg == gnla_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            gnla_pkg::ST_IDLE: begin
                if (s_valid) begin
                    color_reg      <= s_cone_color;
                    range_reg      <= s_cone_range;
                    bearing_reg    <= s_cone_bearing;
                    last_reg       <= s_frame_end;
                    px_reg         <= '0;
                    py_reg         <= '0;
                    res_status_reg <= gnla_pkg::STAT_READY;
                    res_slot_reg   <= '0;
                    res_wv_reg     <= 1'b0;
                    res_width_reg  <= '0;
                    keep_reg       <= 1'b0;
                    found_reg      <= 1'b0;
                end
            end
            gnla_pkg::ST_CORDIC: begin
                if (ch_valid[CORDIC_STEPS]) begin
                    px_reg         <= gnla_pkg::round_sat(ch_data[CORDIC_STEPS].x);
                    py_reg         <= gnla_pkg::round_sat(ch_data[CORDIC_STEPS].y);
                    keep_reg       <= keep_c;
                    best_reg       <= DW'((color_reg == large_orange_reg) ? gate_large_reg
                                                                         : gate_normal_reg);
                    found_reg      <= 1'b0;
                    hit_reg        <= '0;
                    idx_a_reg      <= '0;
                    idx_b_reg      <= '0;
                    res_status_reg <= gnla_pkg::STAT_FILTERED;
                end
            end
            gnla_pkg::ST_SCAN: begin
                if (issue) begin
                    idx_a_reg <= idx_a_reg + 1'b1;
                end
                if (better) begin
                    best_reg  <= scan_dist;
                    hit_reg   <= scan_idx;
                    found_reg <= 1'b1;
                end
            end
            gnla_pkg::ST_FRAME: begin
                if (keep_reg) begin
                    if (found_reg) begin
                        res_status_reg <= gnla_pkg::STAT_MATCHED;
                        res_slot_reg   <= 6'(hit_reg);
                    end else if (wr_en) begin
                        res_status_reg <= gnla_pkg::STAT_NEW;
                        res_slot_reg   <= 6'(mark_count_reg[IW-1:0]);
                    end else begin
                        res_status_reg <= gnla_pkg::STAT_FULL;
                    end
                end
                best_reg  <= gnla_pkg::NO_WIDTH_SQ;
                idx_a_reg <= '0;
                idx_b_reg <= '0;
            end
            gnla_pkg::ST_WIDTH: begin
                if (issue) begin
                    if ((IW+1)'(idx_b_reg + 1'b1) == mark_count_reg) begin
                        idx_b_reg <= '0;
                        idx_a_reg <= idx_a_reg + 1'b1;
                    end else begin
                        idx_b_reg <= idx_b_reg + 1'b1;
                    end
                end
                if (better) begin
                    best_reg <= scan_dist;
                end
                sq_v_reg   <= best_reg[33:0];
                sq_res_reg <= '0;
                sq_bit_reg <= 34'h1_0000_0000;
            end
            gnla_pkg::ST_SQRT: begin
                if (sq_bit_reg != '0) begin
                    if (35'(sq_v_reg) >= sq_trial) begin
                        sq_v_reg   <= 34'(35'(sq_v_reg) - sq_trial);
                        sq_res_reg <= (sq_res_reg >> 1) + 35'(sq_bit_reg);
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                end else begin
                    res_width_reg <= sq_res_reg[16:0];
                    res_wv_reg    <= 1'b1;
                end
            end
            gnla_pkg::ST_OUT: begin
                if (out_free) begin
                    m_status_reg <= res_status_reg;
                    m_slot_reg   <= res_slot_reg;
                    m_x_reg      <= px_reg;
                    m_y_reg      <= py_reg;
                    m_wv_reg     <= res_wv_reg;
                    m_width_reg  <= res_width_reg;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (paddr[5:3])
            gnla_pkg::REG_FAR_RANGE:    prdata = 64'(far_range_reg);
            gnla_pkg::REG_GATE_NORMAL:  prdata = 64'(gate_normal_reg);
            gnla_pkg::REG_GATE_LARGE:   prdata = 64'(gate_large_reg);
            gnla_pkg::REG_FRAMES:       prdata = 64'(frames_needed_reg);
            gnla_pkg::REG_YELLOW:       prdata = 64'(yellow_reg);
            gnla_pkg::REG_BLUE:         prdata = 64'(blue_reg);
            gnla_pkg::REG_LARGE_ORANGE: prdata = 64'(large_orange_reg);
            default:                    prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_landmark_slot = m_slot_reg;
    assign m_pos_x         = m_x_reg;
    assign m_pos_y         = m_y_reg;
    assign m_width_valid   = m_wv_reg;
    assign m_lane_width    = m_width_reg;

endmodule
